// ===== rtl/edf_pkg.sv =====
// Shared types and codes for the EDF deadline run queue.
package edf_pkg;

  localparam int unsigned MaxTasksDef = 16;
  localparam int unsigned TimeBitsDef = 48;

  localparam logic [2:0] OP_SET_PARAMS = 3'd0;
  localparam logic [2:0] OP_RUNNABLE   = 3'd1;
  localparam logic [2:0] OP_REMOVE     = 3'd2;
  localparam logic [2:0] OP_DISPATCH   = 3'd3;
  localparam logic [2:0] OP_PICK       = 3'd4;

  localparam logic [2:0] RSN_USER_YIELD = 3'd0;
  localparam logic [2:0] RSN_YIELD      = 3'd1;
  localparam logic [2:0] RSN_PREEMPT    = 3'd2;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_QUEUED  = 2'd1;
  localparam logic [1:0] STS_NOT_DUE = 2'd2;
  localparam logic [1:0] STS_FULL    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INS,
    ST_RESP
  } state_e;

  // Command broadcast to every slot of the sorted queue.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// ===== rtl/edf_cell.sv =====
// One slot of the deadline-sorted queue: holds a task and its deadline.
module edf_cell import edf_pkg::*; #(
  parameter int unsigned IdxW     = 4,
  parameter int unsigned TimeBits = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctl_t           ctl_i,
  input  logic [IdxW-1:0]     key_tid_i,
  input  logic [TimeBits-1:0] key_dl_i,
  input  logic                prev_valid_i,
  input  logic [IdxW-1:0]     prev_tid_i,
  input  logic [TimeBits-1:0] prev_dl_i,
  input  logic                prev_ahead_i,
  input  logic                prev_hit_i,
  input  logic                next_valid_i,
  input  logic [IdxW-1:0]     next_tid_i,
  input  logic [TimeBits-1:0] next_dl_i,
  output logic                valid_o,
  output logic [IdxW-1:0]     tid_o,
  output logic [TimeBits-1:0] dl_o,
  output logic                ahead_o,
  output logic                hit_o
);

  logic                valid_q, valid_d;
  logic [IdxW-1:0]     tid_q, tid_d;
  logic [TimeBits-1:0] dl_q, dl_d;

  // Entry stays ahead of a new key only when its deadline is strictly earlier.
  assign ahead_o = valid_q && (key_dl_i > dl_q);
  assign hit_o   = prev_hit_i || (valid_q && (tid_q == key_tid_i));

  always_comb begin
    valid_d = valid_q;
    tid_d   = tid_q;
    dl_d    = dl_q;
    if (ctl_i.ins && !ahead_o) begin
      if (prev_ahead_i) begin
        valid_d = 1'b1;
        tid_d   = key_tid_i;
        dl_d    = key_dl_i;
      end else begin
        valid_d = prev_valid_i;
        tid_d   = prev_tid_i;
        dl_d    = prev_dl_i;
      end
    end else if (ctl_i.rem && hit_o) begin
      valid_d = next_valid_i;
      tid_d   = next_tid_i;
      dl_d    = next_dl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q <= tid_d;
    dl_q  <= dl_d;
  end

  assign valid_o = valid_q;
  assign tid_o   = tid_q;
  assign dl_o    = dl_q;

endmodule

// ===== rtl/edf_deadline_run_queue.sv =====
// Top level of the EDF run queue: command decode, task tables, sorted slot chain.
//
//  channel  dir  beat contents (tdata, low bits first)
//  s_axis   in   opcode, task_id, start_time, period_value, dispatch_reason, now_time
//  m_axis   out  status, rerun, picked_valid, picked_task, queued_count
//
// Each command runs from accept through the exec and resp states to its result (with
// the ins state between when a queued task is moved by set params or reinserted by
// dispatch): the slot chain does one insert or one removal per cycle, all slots shifting in parallel.
// Reset clears all task tables, slots and the count at once; no sweep.
// Input is taken only while idle; a held result keeps the sequencer in resp, so no new input is taken.
module edf_deadline_run_queue import edf_pkg::*; #(
  parameter int unsigned MAX_TASKS = MaxTasksDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[2:0], task_id[6:3], start_time[54:7], period_value[86:55],
  // dispatch_reason[89:87], now_time[137:90]
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], rerun[2], picked_valid[3], picked_task[7:4], queued_count[12:8]
  output logic [15:0]  m_axis_tdata
);

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned SumW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

  state_e state_q, state_d;

  logic [2:0]           op_q;
  logic [3:0]           tid_q;
  logic [TIME_BITS-1:0] start_q, now_q;
  logic [31:0]          period_q;
  logic [2:0]           reason_q;

  logic [TIME_BITS-1:0] deadline_q [MAX_TASKS];
  logic [31:0]          tperiod_q  [MAX_TASKS];
  logic [MAX_TASKS-1:0] queued_q;
  logic [CntW-1:0]      count_q;

  logic [1:0]      status_q, status_d;
  logic            rerun_q, rerun_d, pvalid_q, pvalid_d;
  logic [IdxW-1:0] ptask_q, ptask_d;

  logic        out_valid_q;
  logic [15:0] out_data_q;

  // slot chain wiring
  cell_ctl_t            ctl;
  logic [IdxW-1:0]      key_tid;
  logic [TIME_BITS-1:0] key_dl;
  logic [MAX_TASKS-1:0] c_valid, c_ahead, c_hit;
  logic [IdxW-1:0]      c_tid [MAX_TASKS];
  logic [TIME_BITS-1:0] c_dl  [MAX_TASKS];

  logic            tid_ok;
  logic [IdxW-1:0] t_idx;
  logic [SumW-1:0] sum;
  logic [TIME_BITS-1:0] sat_dl;
  logic            in_fire;

  // control outputs of the sequencer
  logic wr_params, wr_sat, set_queued, clr_queued, cnt_inc, cnt_dec;
  logic [IdxW-1:0] clr_idx;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign tid_ok        = 32'(tid_q) < MAX_TASKS;
  assign t_idx         = IdxW'(32'(tid_q));
  assign sum           = SumW'(deadline_q[t_idx]) + SumW'(tperiod_q[t_idx]);
  // Saturate when the sum spills past the time width.
  assign sat_dl = (sum[SumW-1:TIME_BITS] != '0) ? '1 : sum[TIME_BITS-1:0];

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    edf_cell #(
      .IdxW     (IdxW),
      .TimeBits (TIME_BITS)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .ctl_i        (ctl),
      .key_tid_i    (key_tid),
      .key_dl_i     (key_dl),
      .prev_valid_i ((i == 0) ? 1'b0 : c_valid[(i == 0) ? 0 : i-1]),
      .prev_tid_i   (c_tid[(i == 0) ? 0 : i-1]),
      .prev_dl_i    (c_dl[(i == 0) ? 0 : i-1]),
      .prev_ahead_i ((i == 0) ? 1'b1 : c_ahead[(i == 0) ? 0 : i-1]),
      .prev_hit_i   ((i == 0) ? 1'b0 : c_hit[(i == 0) ? 0 : i-1]),
      .next_valid_i ((i == MAX_TASKS-1) ? 1'b0 : c_valid[(i == MAX_TASKS-1) ? i : i+1]),
      .next_tid_i   (c_tid[(i == MAX_TASKS-1) ? i : i+1]),
      .next_dl_i    (c_dl[(i == MAX_TASKS-1) ? i : i+1]),
      .valid_o      (c_valid[i]),
      .tid_o        (c_tid[i]),
      .dl_o         (c_dl[i]),
      .ahead_o      (c_ahead[i]),
      .hit_o        (c_hit[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    rerun_d    = rerun_q;
    pvalid_d   = pvalid_q;
    ptask_d    = ptask_q;
    ctl        = '0;
    key_tid    = t_idx;
    key_dl     = deadline_q[t_idx];
    wr_params  = 1'b0;
    wr_sat     = 1'b0;
    set_queued = 1'b0;
    clr_queued = 1'b0;
    clr_idx    = t_idx;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d  = ST_EXEC;
          status_d = STS_OK;
          rerun_d  = 1'b0;
          pvalid_d = 1'b0;
          ptask_d  = '0;
        end
      end
      ST_EXEC: begin
        state_d = ST_RESP;
        if (op_q == OP_PICK) begin
          if (!c_valid[0] || (now_q < c_dl[0])) begin
            status_d = STS_NOT_DUE;
          end else begin
            ctl.rem    = 1'b1;
            key_tid    = c_tid[0];
            clr_queued = 1'b1;
            clr_idx    = c_tid[0];
            cnt_dec    = 1'b1;
            pvalid_d   = 1'b1;
            ptask_d    = c_tid[0];
          end
        end else if (tid_ok) begin
          case (op_q)
            OP_SET_PARAMS: begin
              wr_params = 1'b1;
              if (queued_q[t_idx]) begin
                ctl.rem    = 1'b1;
                clr_queued = 1'b1;
                cnt_dec    = 1'b1;
                state_d    = ST_INS;
              end
            end
            OP_RUNNABLE: begin
              if (queued_q[t_idx]) begin
                status_d = STS_QUEUED;
              end else if (32'(count_q) >= MAX_TASKS) begin
                status_d = STS_FULL;
              end else begin
                ctl.ins    = 1'b1;
                set_queued = 1'b1;
                cnt_inc    = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (queued_q[t_idx]) begin
                ctl.rem    = 1'b1;
                clr_queued = 1'b1;
                cnt_dec    = 1'b1;
              end
            end
            OP_DISPATCH: begin
              if (reason_q == RSN_USER_YIELD) begin
                if (queued_q[t_idx]) begin
                  status_d = STS_QUEUED;
                end else if (32'(count_q) >= MAX_TASKS) begin
                  status_d = STS_FULL;
                end else begin
                  wr_sat  = 1'b1;
                  state_d = ST_INS;
                end
              end else if (reason_q == RSN_YIELD || reason_q == RSN_PREEMPT) begin
                rerun_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INS: begin
        ctl.ins    = 1'b1;
        set_queued = 1'b1;
        cnt_inc    = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      queued_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        deadline_q[i] <= '0;
        tperiod_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (wr_params) begin
        deadline_q[t_idx] <= start_q;
        tperiod_q[t_idx]  <= period_q;
      end else if (wr_sat) begin
        deadline_q[t_idx] <= sat_dl;
      end
      if (set_queued) begin
        queued_q[t_idx] <= 1'b1;
      end else if (clr_queued) begin
        queued_q[clr_idx] <= 1'b0;
      end
      if (cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cnt_dec) begin
        count_q <= count_q - 1'b1;
      end
      if (state_q == ST_RESP && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= s_axis_tdata[2:0];
      tid_q    <= s_axis_tdata[6:3];
      start_q  <= TIME_BITS'(s_axis_tdata[54:7]);
      period_q <= s_axis_tdata[86:55];
      reason_q <= s_axis_tdata[89:87];
      now_q    <= TIME_BITS'(s_axis_tdata[137:90]);
    end
    status_q <= status_d;
    rerun_q  <= rerun_d;
    pvalid_q <= pvalid_d;
    ptask_q  <= ptask_d;
    if (state_q == ST_RESP && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {3'b000, 5'(32'(count_q)), 4'(32'(ptask_q)), pvalid_q, rerun_q,
                     status_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_slot_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(c_valid))
    else $error("slot occupancy differs from queue count");

  a_flag_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(queued_q))
    else $error("queued flags differ from queue count");

  a_head_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid[0] && c_valid[MAX_TASKS > 1 ? 1 : 0]) |-> (c_dl[0] <= c_dl[MAX_TASKS > 1 ? 1 : 0]))
    else $error("queue head is not the earliest deadline");

endmodule
